// ----- rtl/fie_pkg.sv -----
// Shared widths and types for the force index block.
`default_nettype none

package fie_pkg;

  localparam int PRICE_W  = 31;
  localparam int VOL_W    = 31;
  localparam int FORCE_W  = 64;
  localparam int PERIOD_W = 16;
  localparam int PMAG_W   = PRICE_W + VOL_W;

  // One classified bar on its way from the front end to the back end.
  typedef struct packed {
    logic               first;
    logic               neg;
    logic [PRICE_W-1:0] dmag;
    logic [VOL_W-1:0]   vol;
  } bar_req_t;

  // Status of the smoothing configuration.
  typedef struct packed {
    logic busy;
    logic bypass;
  } cfg_stat_t;

endpackage

`default_nettype wire

// ----- rtl/fie_ifs.sv -----
// Channel interfaces: bar requests, force results and the period write port.
`default_nettype none

interface fie_bar_if;
  logic                         valid;
  logic                         ready;
  logic [fie_pkg::PRICE_W-1:0]  close_price;
  logic [fie_pkg::VOL_W-1:0]    bar_volume;
  modport source (output valid, close_price, bar_volume, input ready);
  modport sink   (input valid, close_price, bar_volume, output ready);
endinterface

interface fie_force_if;
  logic                                valid;
  logic                                ready;
  logic signed [fie_pkg::FORCE_W-1:0]  force_value;
  logic                                primed;
  modport source (output valid, force_value, primed, input ready);
  modport sink   (input valid, force_value, primed, output ready);
endinterface

interface fie_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [fie_pkg::PERIOD_W-1:0]  smoothing_period;
  modport source (output valid, smoothing_period, input ready);
  modport sink   (input valid, smoothing_period, output ready);
endinterface

`default_nettype wire

// ----- rtl/fie_alpha_div.sv -----
// Period register and restoring divider for alpha = 2/(period+1).
`default_nettype none

module fie_alpha_div #(
  parameter int ALPHA_FRAC_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  fie_cfg_if.sink                cfg_wr,
  output fie_pkg::cfg_stat_t     stat,
  output logic [ALPHA_FRAC_BITS:0] alpha
);

  localparam int AW = ALPHA_FRAC_BITS + 1;
  localparam int NW = (ALPHA_FRAC_BITS + 2 > fie_pkg::PERIOD_W + 1) ?
                      ALPHA_FRAC_BITS + 2 : fie_pkg::PERIOD_W + 1;
  localparam int DW = fie_pkg::PERIOD_W + 1;
  localparam int CW = $clog2(NW + 1);

  logic [fie_pkg::PERIOD_W-1:0] period_r, period_nxt;
  logic                         busy_r, busy_nxt;
  logic [CW-1:0]                cnt_r, cnt_nxt;
  logic [NW-1:0]                quot_r, quot_nxt;   // numerator shifts out, quotient in
  logic [DW-1:0]                rem_r, rem_nxt;
  logic [DW-1:0]                den_r, den_nxt;

  logic [DW-1:0] den_c;
  logic [DW:0]   rem_sh;
  logic          ge;

  assign cfg_wr.ready = !busy_r;
  assign stat.busy    = busy_r;
  assign stat.bypass  = (period_r <= fie_pkg::PERIOD_W'(1));
  assign alpha        = quot_r[AW-1:0];

  assign den_c  = {1'b0, cfg_wr.smoothing_period} + DW'(1);
  assign rem_sh = {rem_r, quot_r[NW-1]};
  assign ge     = (rem_sh >= {1'b0, den_r});

  always_comb begin
    period_nxt = period_r;
    busy_nxt   = busy_r;
    cnt_nxt    = cnt_r;
    quot_nxt   = quot_r;
    rem_nxt    = rem_r;
    den_nxt    = den_r;
    if (cfg_wr.valid && cfg_wr.ready) begin
      period_nxt = cfg_wr.smoothing_period;
      busy_nxt   = 1'b1;
      cnt_nxt    = CW'(NW);
      den_nxt    = den_c;
      rem_nxt    = '0;
      // rounded to nearest: (2 << F) + den/2
      quot_nxt   = (NW'(1) << (ALPHA_FRAC_BITS + 1)) + NW'(den_c[DW-1:1]);
    end else if (busy_r) begin
      rem_nxt  = ge ? DW'(rem_sh - {1'b0, den_r}) : rem_sh[DW-1:0];
      quot_nxt = {quot_r[NW-2:0], ge};
      cnt_nxt  = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= fie_pkg::PERIOD_W'(1);
      busy_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      period_r <= period_nxt;
      busy_r   <= busy_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/fie_front.sv -----
// Front end: takes bars, keeps the previous close and classifies each bar.
`default_nettype none

module fie_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  fie_bar_if.sink                  in_bar,
  input  wire fie_pkg::cfg_stat_t  stat,
  input  wire logic                push_ready,
  output logic                     push_valid,
  output fie_pkg::bar_req_t        push_item
);

  logic [fie_pkg::PRICE_W-1:0] last_close_r, last_close_nxt;
  logic                        have_last_r, have_last_nxt;
  logic                        take;

  // no bars while the divider is refreshing alpha
  assign in_bar.ready = push_ready && !stat.busy;
  assign push_valid   = in_bar.valid && !stat.busy;
  assign take         = in_bar.valid && in_bar.ready;

  always_comb begin
    push_item.first = !have_last_r;
    push_item.neg   = (in_bar.close_price < last_close_r);
    push_item.dmag  = push_item.neg ? (last_close_r - in_bar.close_price)
                                    : (in_bar.close_price - last_close_r);
    push_item.vol   = in_bar.bar_volume;
  end

  always_comb begin
    last_close_nxt = last_close_r;
    have_last_nxt  = have_last_r;
    if (take) begin
      last_close_nxt = in_bar.close_price;
      have_last_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_close_r <= '0;
      have_last_r  <= 1'b0;
    end else begin
      last_close_r <= last_close_nxt;
      have_last_r  <= have_last_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/fie_queue.sv -----
// Two-entry request queue between the front and back ends.
`default_nettype none

module fie_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push_valid,
  output logic                    push_ready,
  input  wire fie_pkg::bar_req_t  push_item,
  output logic                    pop_valid,
  input  wire logic               pop_ready,
  output fie_pkg::bar_req_t       pop_item
);

  fie_pkg::bar_req_t mem_r [2];
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/fie_back.sv -----
// Back end: raw force, EMA update and the result register.
`default_nettype none

module fie_back #(
  parameter int ALPHA_FRAC_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                pop_valid,
  output logic                     pop_ready,
  input  wire fie_pkg::bar_req_t   pop_item,
  input  wire fie_pkg::cfg_stat_t  stat,
  input  wire logic [ALPHA_FRAC_BITS:0] alpha,
  fie_force_if.source              out_force
);

  localparam int AW = ALPHA_FRAC_BITS + 1;
  localparam int FW = fie_pkg::FORCE_W;
  localparam int HW = FW / 2;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIFF = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_UPD  = 4'b1000
  } back_state_t;

  back_state_t                   state_r, state_nxt;
  logic                          seeded_r, seeded_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [FW-1:0]                 smoothed_r, smoothed_nxt;
  fie_pkg::bar_req_t             item_r, item_nxt;
  logic [fie_pkg::PMAG_W-1:0]    pmag_r, pmag_nxt;
  logic [FW-1:0]                 d_r, d_nxt;
  logic [HW+AW-1:0]              plo_r, plo_nxt;
  logic signed [HW+AW:0]         phi_r, phi_nxt;
  logic signed [FW-1:0]          out_force_r, out_force_nxt;
  logic                          out_primed_r, out_primed_nxt;

  logic                          out_free;
  logic [FW-1:0]                 p64, psel, raw_c, d_c;
  logic signed [FW+AW:0]         full_c, step_c;

  assign out_free          = !out_valid_r || out_force.ready;
  assign pop_ready         = (state_r == ST_IDLE);
  assign out_force.valid       = out_valid_r;
  assign out_force.force_value = out_force_r;
  assign out_force.primed      = out_primed_r;

  // |raw| < 2^62, so it fits in 64 bits with no clamp
  assign p64   = {{(FW - fie_pkg::PMAG_W){1'b0}}, pmag_r};
  assign psel  = item_r.neg ? ~p64 : p64;
  assign raw_c = item_r.neg ? (~p64 + FW'(1)) : p64;
  assign d_c   = psel + ~smoothed_r + (item_r.neg ? FW'(2) : FW'(1));

  assign full_c = $signed({phi_r, {HW{1'b0}}}) + $signed({1'b0, plo_r});
  assign step_c = full_c >>> ALPHA_FRAC_BITS;

  always_comb begin
    state_nxt      = state_r;
    seeded_nxt     = seeded_r;
    out_valid_nxt  = out_valid_r;
    smoothed_nxt   = smoothed_r;
    item_nxt       = item_r;
    pmag_nxt       = pmag_r;
    d_nxt          = d_r;
    plo_nxt        = plo_r;
    phi_nxt        = phi_r;
    out_force_nxt  = out_force_r;
    out_primed_nxt = out_primed_r;

    if (out_valid_r && out_force.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (pop_valid) begin
          item_nxt  = pop_item;
          pmag_nxt  = fie_pkg::PMAG_W'(pop_item.dmag) * fie_pkg::PMAG_W'(pop_item.vol);
          state_nxt = ST_DIFF;
        end
      end
      ST_DIFF: begin
        if (item_r.first) begin
          if (out_free) begin
            out_force_nxt  = '0;
            out_primed_nxt = 1'b0;
            out_valid_nxt  = 1'b1;
            state_nxt      = ST_IDLE;
          end
        end else if (stat.bypass || !seeded_r) begin
          if (out_free) begin
            smoothed_nxt   = raw_c;
            seeded_nxt     = 1'b1;
            out_force_nxt  = raw_c;
            out_primed_nxt = 1'b1;
            out_valid_nxt  = 1'b1;
            state_nxt      = ST_IDLE;
          end
        end else begin
          d_nxt     = d_c;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        // difference times alpha, split in two 32-bit halves
        plo_nxt   = d_r[HW-1:0] * alpha;
        phi_nxt   = $signed(d_r[FW-1:HW]) * $signed({1'b0, alpha});
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (out_free) begin
          smoothed_nxt   = smoothed_r + step_c[FW-1:0];
          out_force_nxt  = smoothed_r + step_c[FW-1:0];
          out_primed_nxt = 1'b1;
          out_valid_nxt  = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seeded_r    <= 1'b0;
      out_valid_r <= 1'b0;
      smoothed_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      seeded_r    <= seeded_nxt;
      out_valid_r <= out_valid_nxt;
      smoothed_r  <= smoothed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r       <= item_nxt;
    pmag_r       <= pmag_nxt;
    d_r          <= d_nxt;
    plo_r        <= plo_nxt;
    phi_r        <= phi_nxt;
    out_force_r  <= out_force_nxt;
    out_primed_r <= out_primed_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/force_index_ema.sv -----
// Top level of the EMA-smoothed force index block.
`default_nettype none

// Elder force index, one bar per request. A bar carries a close price in
// ticks and a volume; each bar gives exactly one result. The first bar after
// reset only stores its close and returns force_value 0 with primed low.
// Every later bar forms raw = (close - previous close) * volume and returns
// either raw itself (period 0 or 1, or the first raw value after reset) or
// the EMA ema += (alpha * (raw - ema)) >>> ALPHA_FRAC_BITS with
// alpha = 2/(period+1) rounded to nearest in Q1.ALPHA_FRAC_BITS.
// Sequencing: a smoothed bar goes through the back-end sequencer steps volume
// multiply, difference, split alpha multiply and update; an unsmoothed or
// first bar goes through volume multiply and difference only. The sequencer
// takes a new bar only when idle. A two-deep queue lets the front end keep
// taking bars while the back end works or the result register waits on
// out_force. A period write starts a restoring divider; cfg_wr and in_bar
// are both held off while it runs.
module force_index_ema #(
  parameter int ALPHA_FRAC_BITS = 16
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  fie_bar_if.sink     in_bar,
  fie_force_if.source out_force,
  fie_cfg_if.sink     cfg_wr
);

  fie_pkg::cfg_stat_t          stat;
  logic [ALPHA_FRAC_BITS:0]    alpha;

  logic                        push_valid, push_ready;
  fie_pkg::bar_req_t           push_item;
  logic                        pop_valid, pop_ready;
  fie_pkg::bar_req_t           pop_item;

  // period register plus alpha divider
  fie_alpha_div #(
    .ALPHA_FRAC_BITS(ALPHA_FRAC_BITS)
  ) u_alpha_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_wr (cfg_wr),
    .stat   (stat),
    .alpha  (alpha)
  );

  // previous close and classification of each bar
  fie_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bar     (in_bar),
    .stat       (stat),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_item  (push_item)
  );

  fie_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // raw force, EMA state and result register
  fie_back #(
    .ALPHA_FRAC_BITS(ALPHA_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .stat      (stat),
    .alpha     (alpha),
    .out_force (out_force)
  );

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking testbench for the EMA-smoothed force index block.
`timescale 1ns / 1ps

module tb;

  // Alpha precision used both for the block and for the predictor below.
  localparam int ALPHA_F = 16;
  localparam int HOLD_CYCLES = 150;       // long stall on the result side
  localparam int CYCLE_LIMIT = 400000;    // watchdog, far above the slowest run
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 62;

  localparam logic [fie_pkg::PRICE_W-1:0] MAX_PRICE = {fie_pkg::PRICE_W{1'b1}};
  localparam logic [fie_pkg::VOL_W-1:0]   MAX_VOL   = {fie_pkg::VOL_W{1'b1}};

  // One expected result: smoothed force and the primed flag.
  typedef struct {
    logic signed [fie_pkg::FORCE_W-1:0] force_v;
    logic                               primed;
  } force_exp_t;

  // Scoreboard: tracks the bar history and EMA state, queues the expected
  // force values in request order and checks each returned result.
  class force_book;
    logic [fie_pkg::PERIOD_W-1:0]       period;
    logic [fie_pkg::PRICE_W-1:0]        last_bar_close;
    bit                                 have_prev;
    bit                                 ema_live;
    logic signed [fie_pkg::FORCE_W-1:0] ema;
    force_exp_t                         due[$];
    int                                 errors;

    function new();
      period = 1;
      last_bar_close = '0;
      have_prev = 0;
      ema_live = 0;
      ema = '0;
      errors = 0;
    endfunction

    function void set_period(logic [fie_pkg::PERIOD_W-1:0] p);
      period = p;
    endfunction

    function void take_bar(logic [fie_pkg::PRICE_W-1:0] close_p,
                           logic [fie_pkg::VOL_W-1:0] vol);
      logic signed [fie_pkg::FORCE_W-1:0] diff;
      logic signed [fie_pkg::FORCE_W-1:0] raw;
      logic signed [fie_pkg::FORCE_W-1:0] delta;
      logic signed [127:0]                prod;
      int unsigned                        den;
      int unsigned                        alpha;
      force_exp_t                         e;
      if (!have_prev) begin
        // first bar only records its close
        have_prev = 1;
        last_bar_close = close_p;
        e.force_v = '0;
        e.primed = 1'b0;
        due.push_back(e);
        return;
      end
      // |diff| < 2^31 and vol < 2^31, so raw fits in 64 bits with no clamp
      diff = $signed(64'(close_p)) - $signed(64'(last_bar_close));
      raw = diff * $signed(64'(vol));
      if (period <= 1 || !ema_live) begin
        ema = raw;
        ema_live = 1;
      end else begin
        den = period + 1;
        alpha = ((32'd2 << ALPHA_F) + den / 2) / den;
        delta = raw - ema;
        // exact product, then floor shift (arithmetic)
        prod = $signed({{64{delta[fie_pkg::FORCE_W-1]}}, delta}) * $signed({96'd0, alpha});
        ema = ema + prod[ALPHA_F +: fie_pkg::FORCE_W];
      end
      last_bar_close = close_p;
      e.force_v = ema;
      e.primed = 1'b1;
      due.push_back(e);
    endfunction

    function void check_result(logic signed [fie_pkg::FORCE_W-1:0] fv, logic pr);
      force_exp_t e;
      if (due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result force_value=%0d primed=%0b", $time, fv, pr);
        return;
      end
      e = due.pop_front();
      if (fv !== e.force_v) begin
        errors++;
        $display("%0t: force_value mismatch expected %0d actual %0d",
                 $time, e.force_v, fv);
      end
      if (pr !== e.primed) begin
        errors++;
        $display("%0t: primed mismatch expected %0b actual %0b", $time, e.primed, pr);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  fie_bar_if   bar_ch ();
  fie_force_if force_ch ();
  fie_cfg_if   cfg_ch ();

  force_index_ema #(
    .ALPHA_FRAC_BITS(ALPHA_F)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bar    (bar_ch),
    .out_force (force_ch),
    .cfg_wr    (cfg_ch)
  );

  force_book book = new();

  // Idle control: per-side no-gap stretches, and the long result hold-off.
  bit             no_gaps_in;
  bit             no_gaps_out;
  bit             hold_req;
  logic           hold_off;
  logic [fie_pkg::PRICE_W-1:0] price_walk;   // last close sent, drives the random walk
  int unsigned    cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, book.due.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Monitor: every handshake is sampled at the edge it completes on.
  // Requests feed the predictor, period writes update its copy of the
  // register, results are checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n) begin
      if (bar_ch.valid && bar_ch.ready)
        book.take_bar(bar_ch.close_price, bar_ch.bar_volume);
      if (cfg_ch.valid && cfg_ch.ready)
        book.set_period(cfg_ch.smoothing_period);
      if (force_ch.valid && force_ch.ready)
        book.check_result(force_ch.force_value, force_ch.primed);
    end
  end

  // Long hold-off on the result side, counted here in cycles. While it runs
  // the sender keeps offering requests so the internal queue fills up.
  initial begin
    hold_off <= 1'b0;
    forever begin
      wait (hold_req);
      hold_req = 0;
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_off <= 1'b0;
    end
  end

  // Result sink: random stall before each result, none in
  // a no-gap stretch, and nothing at all while the hold-off is active.
  initial begin
    int stall;
    force_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = no_gaps_out ? 0 : $urandom_range(0, 10);
      if (stall > 0 || hold_off) begin
        force_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
        while (hold_off) @(posedge clk);
      end
      force_ch.ready <= 1'b1;
      do @(posedge clk); while (!(force_ch.valid && force_ch.ready));
    end
  end

  // Offer one bar after a random gap; returns at the accepting edge with
  // valid still high so back-to-back requests need no extra cycle.
  task automatic send_bar(logic [fie_pkg::PRICE_W-1:0] close_p,
                          logic [fie_pkg::VOL_W-1:0] vol);
    int gap;
    gap = no_gaps_in ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      bar_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    bar_ch.valid       <= 1'b1;
    bar_ch.close_price <= close_p;
    bar_ch.bar_volume  <= vol;
    price_walk = close_p;
    do @(posedge clk); while (!(bar_ch.valid && bar_ch.ready));
  endtask

  // Stop offering and wait until every expected result is back. Always
  // advances to a clock edge before returning, so valid is never lowered and raised in
  // the same step.
  task automatic wait_idle();
    bar_ch.valid <= 1'b0;
    do @(posedge clk); while (book.due.size() != 0);
  endtask

  // Period write, only ever issued with the block drained. The divider
  // start is covered by cfg ready, so we just wait for the handshake.
  task automatic write_period(logic [fie_pkg::PERIOD_W-1:0] p);
    wait_idle();
    cfg_ch.valid            <= 1'b1;
    cfg_ch.smoothing_period <= p;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    cfg_ch.valid <= 1'b0;
  endtask

  // Random bar: mostly a price walk with modest volume (the realistic case
  // that keeps the EMA meaningful), plus full-range noise and extremes.
  task automatic pick_bar(output logic [fie_pkg::PRICE_W-1:0] close_p,
                          output logic [fie_pkg::VOL_W-1:0] vol);
    longint nc;
    case ($urandom_range(0, 9))
      0, 1: begin
        close_p = fie_pkg::PRICE_W'($urandom);
        vol     = fie_pkg::VOL_W'($urandom);
      end
      2, 3, 4, 5, 6: begin
        nc = longint'(price_walk) + $urandom_range(0, 2000) - 1000;
        if (nc < 0) nc = 0;
        if (nc > longint'(MAX_PRICE)) nc = longint'(MAX_PRICE);
        close_p = fie_pkg::PRICE_W'(nc);
        vol     = fie_pkg::VOL_W'($urandom_range(0, 1000000));
      end
      7: begin
        // unchanged close: raw force is zero
        close_p = price_walk;
        vol     = fie_pkg::VOL_W'($urandom);
      end
      8: begin
        nc = longint'(price_walk) + $urandom_range(0, 2 ** 21) - 2 ** 20;
        if (nc < 0) nc = 0;
        if (nc > longint'(MAX_PRICE)) nc = longint'(MAX_PRICE);
        close_p = fie_pkg::PRICE_W'(nc);
        vol     = fie_pkg::VOL_W'($urandom_range(0, 65535));
      end
      default: begin
        close_p = $urandom_range(0, 1) ? MAX_PRICE : '0;
        vol     = $urandom_range(0, 1) ? MAX_VOL : '0;
      end
    endcase
  endtask

  // One random phase. Optionally starts the long result hold-off early on
  // with the sender running flat out, or pauses the sender halfway until
  // the block has drained.
  task automatic run_phase(int n_items, bit with_hold, bit with_pause);
    logic [fie_pkg::PRICE_W-1:0] c;
    logic [fie_pkg::VOL_W-1:0]   v;
    bit                          saved_in;
    saved_in = no_gaps_in;
    for (int i = 0; i < n_items; i++) begin
      if (with_hold && i == 5) begin
        hold_req = 1;
        no_gaps_in = 1;
      end
      if (with_hold && i == 25) no_gaps_in = saved_in;
      if (with_pause && i == n_items / 2) wait_idle();
      pick_bar(c, v);
      send_bar(c, v);
    end
  endtask

  logic [fie_pkg::PERIOD_W-1:0] plist [PHASES] = '{16'd3, 16'd1, 16'd10, 16'd65535,
                                                  16'd0, 16'd2, 16'd7, 16'd20,
                                                  16'd65534, 16'd4, 16'd100, 16'd1};

  initial begin
    rst_n                   <= 1'b0;
    bar_ch.valid            <= 1'b0;
    bar_ch.close_price      <= '0;
    bar_ch.bar_volume       <= '0;
    cfg_ch.valid            <= 1'b0;
    cfg_ch.smoothing_period <= '0;
    no_gaps_in  = 0;
    no_gaps_out = 0;
    hold_req    = 0;
    price_walk  = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, period still at its reset value of 1 (no smoothing).
    send_bar(31'd1000, 31'd5);        // first bar: stores close, result 0
    send_bar(31'd1010, 31'd3);        // small positive force
    send_bar(31'd1010, MAX_VOL);      // unchanged close
    send_bar('0, MAX_VOL);            // large drop
    send_bar(MAX_PRICE, MAX_VOL);     // largest positive raw force
    send_bar('0, MAX_VOL);            // largest negative raw force
    send_bar(31'd5, '0);              // zero volume

    // Period zero behaves like period 1.
    write_period('0);
    send_bar(31'd7, 31'd100);
    send_bar(31'd3, 31'd1);

    // Shortest real EMA, with full-scale swings both ways.
    write_period(16'd2);
    send_bar(MAX_PRICE, MAX_VOL);
    send_bar('0, MAX_VOL);
    send_bar('0, 31'd12345);
    send_bar(31'd1, 31'd1);

    // Longest period: alpha is tiny, the EMA barely moves.
    write_period(16'hFFFF);
    send_bar(MAX_PRICE, MAX_VOL);
    send_bar('0, MAX_VOL);
    send_bar(31'd12, 31'd7);

    // Random phases over a spread of periods, two of them drawn at random.
    plist[6] = fie_pkg::PERIOD_W'($urandom_range(2, 64));
    plist[9] = fie_pkg::PERIOD_W'($urandom_range(2, 65535));
    for (int k = 0; k < PHASES; k++) begin
      write_period(plist[k]);
      no_gaps_in  = (k == 7) || ($urandom_range(0, 3) == 0);
      no_gaps_out = (k == 7) || ($urandom_range(0, 3) == 0);
      run_phase(PHASE_ITEMS, k == 3, k == 5);
    end

    // Drain, then allow a few more cycles for anything stray to show up.
    wait_idle();
    repeat (20) @(posedge clk);
    if (book.due.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, book.due.size());
      book.errors++;
    end
    if (book.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
